@@ rtl/core/wma_pkg.sv @@
// Shared constants and types for the three-axis weighted moving average.
// No dependencies; every other file of the block imports this package.
package wma_pkg;

	localparam int WMA_WINDOW      = 32;
	localparam int WMA_SAMPLE_BITS = 16;
	localparam int WMA_AXES        = 3;

	// Control that travels with a beat out of the sample ring stage.
	typedef struct packed {
		logic valid;
		logic wrapped;
	} wma_ctl_t;

endpackage

@@ rtl/core/wma_in_if.sv @@
// Input sample channel: valid/ready handshake with one three-axis sample.
// Depends on wma_pkg for the default sample width.
interface wma_in_if
	import wma_pkg::*;
	#(parameter int SAMPLE_BITS = WMA_SAMPLE_BITS);

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] x_in;
	logic [SAMPLE_BITS-1:0] y_in;
	logic [SAMPLE_BITS-1:0] z_in;

	modport source (output valid, output x_in, output y_in, output z_in, input ready);
	modport sink   (input valid, input x_in, input y_in, input z_in, output ready);

endinterface

@@ rtl/core/wma_out_if.sv @@
// Output average channel: valid/ready handshake with one three-axis result.
// Depends on wma_pkg for the default sample width.
interface wma_out_if
	import wma_pkg::*;
	#(parameter int SAMPLE_BITS = WMA_SAMPLE_BITS);

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] x_out;
	logic [SAMPLE_BITS-1:0] y_out;
	logic [SAMPLE_BITS-1:0] z_out;

	modport source (output valid, output x_out, output y_out, output z_out, input ready);
	modport sink   (input valid, input x_out, input y_out, input z_out, output ready);

endinterface

@@ rtl/core/wma_ring.sv @@
// Sample ring: read-first memory of the last WINDOW samples plus write slot.
// Depends on wma_pkg. Feeds the accumulator with the fresh and evicted samples.
module wma_ring
	import wma_pkg::*;
	#(
	parameter int WINDOW      = WMA_WINDOW,
	parameter int SAMPLE_BITS = WMA_SAMPLE_BITS
	) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   accept,
	input  logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  fresh,
	output wma_ctl_t                               ctl_s1,
	output logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  fresh_s1,
	output logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  evict_s1
);

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

	logic [WMA_AXES*SAMPLE_BITS-1:0] mem [WINDOW];
	logic [AW-1:0] slot_q;
	logic          wrapped_q;

	// Read-first: the old entry comes out in the same cycle the new one goes in.
	always_ff @(posedge clk) begin
		if (accept) begin
			evict_s1      <= mem[slot_q];
			mem[slot_q]   <= fresh;
			fresh_s1      <= fresh;
		end
	end

	// Entries are never cleared; until the first wrap the slot read was never
	// written and counts as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			ctl_s1    <= '0;
		end else begin
			if (accept) begin
				if (slot_q == LAST_SLOT) begin
					slot_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					slot_q <= slot_q + AW'(1);
				end
			end
			if (en) begin
				ctl_s1.valid   <= accept;
				ctl_s1.wrapped <= wrapped_q;
			end
		end
	end

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && slot_q == LAST_SLOT |=> slot_q == '0 && wrapped_q)
		else $error("slot did not wrap to zero");

	a_wrapped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("wrap flag cleared outside reset");

	a_accept_en: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ctl_s1.valid)
		else $error("accepted beat lost at ring stage");

endmodule

@@ rtl/core/wma_accum.sv @@
// Running plain and weighted sums per axis, one update per beat.
// Depends on wma_pkg; takes the ring stage outputs, feeds the divider.
module wma_accum
	import wma_pkg::*;
	#(
	parameter int WINDOW      = WMA_WINDOW,
	parameter int SAMPLE_BITS = WMA_SAMPLE_BITS,
	localparam int TOTAL      = WINDOW * (WINDOW + 1) / 2,
	localparam int WW         = SAMPLE_BITS + $clog2(TOTAL)
	) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  wma_ctl_t                               ctl_s1,
	input  logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  fresh_s1,
	input  logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  evict_s1,
	output logic                                   valid_s2,
	output logic [WMA_AXES-1:0][WW-1:0]           wsum_q
);

	localparam int PW = SAMPLE_BITS + $clog2(WINDOW);
	localparam logic [WW-1:0] WMUL = WW'(WINDOW);

	logic [WMA_AXES-1:0][PW-1:0] psum_q;
	logic [WMA_AXES-1:0][WW-1:0] wsum_d;
	logic [WMA_AXES-1:0][PW-1:0] psum_d;
	logic                        upd;

	assign upd = en && ctl_s1.valid;

	// W' = W + WINDOW*new - P ; P' = P + new - evicted (two's complement, wraps safely)
	always_comb begin
		for (int a = 0; a < WMA_AXES; a++) begin
			wsum_d[a] = wsum_q[a] + WMUL * WW'($signed(fresh_s1[a]))
				- WW'($signed(psum_q[a]));
			psum_d[a] = psum_q[a] + PW'($signed(fresh_s1[a]))
				- (ctl_s1.wrapped ? PW'($signed(evict_s1[a])) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q   <= '0;
			psum_q   <= '0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= ctl_s1.valid;
			if (upd) begin
				wsum_q <= wsum_d;
				psum_q <= psum_d;
			end
		end
	end

	a_sums_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(psum_q) && $stable(wsum_q))
		else $error("sums changed without a beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s2))
		else $error("accumulator output moved during stall");

endmodule

@@ rtl/core/wma_div.sv @@
// Division of the weighted sums by the total weight through a reciprocal multiply.
// Depends on wma_pkg; sign split, then multiply and shift, truncates toward zero.
module wma_div
	import wma_pkg::*;
	#(
	parameter int WINDOW      = WMA_WINDOW,
	parameter int SAMPLE_BITS = WMA_SAMPLE_BITS,
	localparam int TOTAL      = WINDOW * (WINDOW + 1) / 2,
	localparam int WW         = SAMPLE_BITS + $clog2(TOTAL)
	) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   valid_in,
	input  logic [WMA_AXES-1:0][WW-1:0]           wsum,
	output logic                                   valid_out,
	output logic [WMA_AXES-1:0][SAMPLE_BITS-1:0]  quo
);

	// |sum| < 2^(WW-1) and the reciprocal error is below TOTAL <= 2^CW, so a shift
	// of WW-1+CW makes floor(mag*RECIP >> K) exact. The quotient is the top SAMPLE_BITS.
	localparam int CW  = $clog2(TOTAL);
	localparam int K   = WW - 1 + CW;
	localparam int PRW = 2 * WW - 1;
	localparam logic [127:0] SCALE = 128'(1) << K;
	localparam logic [WW-1:0] RECIP = WW'((SCALE + 128'(TOTAL) - 128'(1)) / 128'(TOTAL));

	logic                                 vld_s3;
	logic                                 vld_s4;
	logic [WMA_AXES-1:0]                  neg_s3;
	logic [WMA_AXES-1:0]                  neg_s4;
	logic [WMA_AXES-1:0][WW-1:0]          abs_w;
	logic [WMA_AXES-1:0][WW-2:0]          mag_s3;
	logic [WMA_AXES-1:0][PRW-1:0]         prod_s4;

	always_comb begin
		for (int a = 0; a < WMA_AXES; a++) begin
			abs_w[a] = wsum[a][WW-1] ? (~wsum[a] + WW'(1)) : wsum[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < WMA_AXES; a++) begin
				neg_s3[a]  <= wsum[a][WW-1];
				mag_s3[a]  <= abs_w[a][WW-2:0];
				neg_s4[a]  <= neg_s3[a];
				prod_s4[a] <= PRW'(mag_s3[a]) * PRW'(RECIP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= valid_in;
			vld_s4 <= vld_s3;
		end
	end

	assign valid_out = vld_s4;

	always_comb begin
		for (int a = 0; a < WMA_AXES; a++) begin
			quo[a] = neg_s4[a] ? (~prod_s4[a][PRW-1:K] + SAMPLE_BITS'(1))
				: prod_s4[a][PRW-1:K];
		end
	end

	a_pipe_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_in |=> vld_s3)
		else $error("beat dropped entering divider");

	a_pipe_follow: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 |=> vld_s4)
		else $error("beat dropped inside divider");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s3) && $stable(vld_s4))
		else $error("divider valid moved during stall");

endmodule

@@ rtl/core/three_axis_weighted_moving_average.sv @@
// Three-axis linearly weighted moving average over the last WINDOW samples.
// Depends on wma_pkg, wma_in_if, wma_out_if, wma_ring, wma_accum, wma_div.
//
// Usage:
//   smp (sink)  : one x/y/z sample per beat; taken when valid and ready are high.
//   avg (source): one x/y/z average per sample beat, in order; newest sample
//                 weighted WINDOW, oldest weighted 1, sum divided by
//                 WINDOW*(WINDOW+1)/2 and truncated toward zero.
// Throughput: one sample per cycle outside stalls. The sums are updated once
//   per beat in a read-modify-write of the ring memory at the write slot.
// Pipeline: from the input beat to the result on avg the beat passes the
//   ring read, sum update, sign split and reciprocal multiply registers and
//   is then loaded into the output register.
// Reset: arst_n clears the slot, the sums and all valid bits; the ring is not
//   swept, a wrap flag makes never-written slots count as zero samples, so a
//   sample can be taken in the first cycle after reset.
// Stall: when avg.ready is low the output register and a skid register fill;
//   smp.ready is low while the skid is full, and the whole pipeline holds.
module three_axis_weighted_moving_average
	import wma_pkg::*;
	#(
	parameter int WINDOW      = WMA_WINDOW,
	parameter int SAMPLE_BITS = WMA_SAMPLE_BITS
	) (
	input  logic       clk,
	input  logic       arst_n,
	wma_in_if.sink     smp,
	wma_out_if.source  avg
);

	localparam int TOTAL = WINDOW * (WINDOW + 1) / 2;
	localparam int WW    = SAMPLE_BITS + $clog2(TOTAL);

	logic                                  en;
	logic                                  accept;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] fresh;
	wma_ctl_t                              ctl_s1;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] fresh_s1;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] evict_s1;
	logic                                  valid_s2;
	logic [WMA_AXES-1:0][WW-1:0]          wsum;
	logic                                  div_valid;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] div_quo;

	logic                                  main_v_q;
	logic                                  skid_v_q;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] main_q;
	logic [WMA_AXES-1:0][SAMPLE_BITS-1:0] skid_q;
	logic                                  push;
	logic                                  pop;

	// Pipeline advances whenever the skid register is free.
	assign en        = !skid_v_q;
	assign smp.ready = en;
	assign accept    = smp.valid && en;
	assign fresh     = {smp.z_in, smp.y_in, smp.x_in};

	wma_ring #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.accept   (accept),
		.fresh    (fresh),
		.ctl_s1   (ctl_s1),
		.fresh_s1 (fresh_s1),
		.evict_s1 (evict_s1)
	);

	wma_accum #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s1   (ctl_s1),
		.fresh_s1 (fresh_s1),
		.evict_s1 (evict_s1),
		.valid_s2 (valid_s2),
		.wsum_q   (wsum)
	);

	wma_div #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s2),
		.wsum      (wsum),
		.valid_out (div_valid),
		.quo       (div_quo)
	);

	assign push = en && div_valid;
	assign pop  = main_v_q && avg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= div_quo;
			end else begin
				main_q <= div_quo;
			end
		end
	end

	assign avg.valid = main_v_q;
	assign avg.x_out = main_q[0];
	assign avg.y_out = main_q[1];
	assign avg.z_out = main_q[2];

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid register holds a beat while output register is empty");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && avg.ready |=> !skid_v_q && main_v_q)
		else $error("skid beat not moved to output register");

endmodule

@@ tb/sv/wma_average_checker.sv @@
`timescale 1ns / 1ps
// Checker for the three-axis weighted moving average: watches both channels,
// predicts every average and compares. Depends on wma_pkg, wma_in_if, wma_out_if.
module wma_average_checker
	import wma_pkg::*;
	(
	input  logic clk,
	input  logic arst_n,
	wma_in_if    smp,
	wma_out_if   avg,
	output int   mismatches,
	output int   pending_avgs
);

	typedef logic [WMA_AXES-1:0][WMA_SAMPLE_BITS-1:0] triple_t;

	localparam longint WEIGHT_TOTAL = longint'(WMA_WINDOW) * (WMA_WINDOW + 1) / 2;

	// Shadow of the window: per-axis history, slot and running sums.
	logic signed [WMA_SAMPLE_BITS-1:0] history [WMA_WINDOW][WMA_AXES];
	int unsigned                       oldest_slot;
	longint                            plain_sum [WMA_AXES];
	longint                            weighted_sum [WMA_AXES];

	triple_t expected_avgs [$];
	string   axis_name [WMA_AXES] = '{"x", "y", "z"};

	function automatic triple_t next_average(input triple_t fresh_raw);
		triple_t avg_word;
		longint  fresh;
		longint  evicted;
		longint  quotient;
		int      a;
		for (a = 0; a < WMA_AXES; a++) begin
			fresh = longint'(signed'(fresh_raw[a]));
			evicted = longint'(history[oldest_slot][a]);
			weighted_sum[a] = weighted_sum[a] + WMA_WINDOW * fresh - plain_sum[a];
			plain_sum[a] = plain_sum[a] + fresh - evicted;
			history[oldest_slot][a] = fresh[WMA_SAMPLE_BITS-1:0];
			// signed division truncates toward zero
			quotient = weighted_sum[a] / WEIGHT_TOTAL;
			avg_word[a] = quotient[WMA_SAMPLE_BITS-1:0];
		end
		oldest_slot = (oldest_slot + 1 >= WMA_WINDOW) ? 0 : oldest_slot + 1;
		return avg_word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		triple_t got;
		triple_t want;
		int      a;
		if (!arst_n) begin
			for (int s = 0; s < WMA_WINDOW; s++)
				for (a = 0; a < WMA_AXES; a++)
					history[s][a] = '0;
			for (a = 0; a < WMA_AXES; a++) begin
				plain_sum[a] = 0;
				weighted_sum[a] = 0;
			end
			oldest_slot = 0;
			expected_avgs.delete();
			mismatches = 0;
			pending_avgs <= 0;
		end else begin
			if (smp.valid && smp.ready)
				expected_avgs.push_back(next_average({smp.z_in, smp.y_in, smp.x_in}));
			if (avg.valid && avg.ready) begin
				got = {avg.z_out, avg.y_out, avg.x_out};
				if (expected_avgs.size() == 0) begin
					$display("%0t: average beat with no sample pending: x=%0d y=%0d z=%0d",
						$time, $signed(got[0]), $signed(got[1]), $signed(got[2]));
					mismatches++;
				end else begin
					want = expected_avgs.pop_front();
					for (a = 0; a < WMA_AXES; a++)
						if (got[a] !== want[a]) begin
							$display("%0t: %s_out expected %0d actual %0d", $time,
								axis_name[a], $signed(want[a]), $signed(got[a]));
							mismatches++;
						end
				end
			end
			pending_avgs <= expected_avgs.size();
		end
	end

endmodule

@@ tb/sv/tb_three_axis_weighted_moving_average.sv @@
`timescale 1ns / 1ps
// Top of the weighted moving average testbench: clock, reset, sample stimulus
// and output back-pressure. Depends on wma_pkg, both channel interfaces and the checker.
module tb_three_axis_weighted_moving_average
	import wma_pkg::*;
	();

	localparam int          ITEM_TARGET  = 400;
	localparam int          HOLD_BEATS   = 60;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [15:0] MAX_POS      = 16'h7FFF;
	localparam logic [15:0] MIN_NEG      = 16'h8000;
	localparam logic [15:0] MINUS_ONE    = 16'hFFFF;

	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_pattern_t;
	typedef enum {FLAVOR_ANY, FLAVOR_EDGE, FLAVOR_SMALL} sample_flavor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_req = 1'b0;
	int   fail_count;
	int   pending;
	int   beats_sent = 0;
	int   cycle_count = 0;

	wma_in_if  smp_if ();
	wma_out_if avg_if ();

	three_axis_weighted_moving_average dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_if),
		.avg    (avg_if)
	);

	wma_average_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp_if),
		.avg          (avg_if),
		.mismatches   (fail_count),
		.pending_avgs (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one sample and hold it until the beat is taken.
	task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		smp_if.valid <= 1'b1;
		smp_if.x_in <= x;
		smp_if.y_in <= y;
		smp_if.z_in <= z;
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	function automatic logic [15:0] pick_sample(input sample_flavor_t flavor);
		case (flavor)
		FLAVOR_EDGE: begin
			case ($urandom_range(0, 3))
			0: return MAX_POS;
			1: return MIN_NEG;
			2: return MINUS_ONE;
			default: return 16'h0000;
			endcase
		end
		FLAVOR_SMALL: return 16'($signed($urandom_range(0, 64)) - 32);
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		smp_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Output side: changing stall patterns, plus one long hold-off on request.
	initial begin : receiver
		ready_pattern_t pattern;
		int unsigned    pattern_left;
		int unsigned    tick;
		logic           hold_served;
		pattern = READY_ALWAYS;
		pattern_left = 0;
		tick = 0;
		hold_served = 1'b0;
		avg_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				avg_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
				avg_if.ready <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					pattern = ready_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(32, 200);
				end
				pattern_left--;
				tick++;
				case (pattern)
				READY_ALWAYS:  avg_if.ready <= 1'b1;
				READY_COIN:    avg_if.ready <= 1'($urandom_range(0, 1));
				READY_SPARSE:  avg_if.ready <= ($urandom_range(0, 3) == 0);
				default:       avg_if.ready <= ((tick % 7) < 4);
				endcase
			end
		end
	end

	initial begin : stimulus
		sample_flavor_t flavor;
		int             burst;
		int             gap;
		logic [15:0]    cx;
		logic [15:0]    cy;
		logic [15:0]    cz;
		smp_if.valid = 1'b0;
		smp_if.x_in = '0;
		smp_if.y_in = '0;
		smp_if.z_in = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start-up from the cleared window, extremes on every axis.
		send_sample(MAX_POS, MIN_NEG, 16'h0000);
		send_sample(MIN_NEG, MAX_POS, MINUS_ONE);
		send_sample(16'h0001, MINUS_ONE, MAX_POS);
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h5555, 16'hAAAA, MIN_NEG);
		send_sample(16'hAAAA, 16'h5555, MAX_POS);
		repeat (10) send_sample(MAX_POS, MIN_NEG, MAX_POS);
		for (int i = 0; i < 6; i++)
			send_sample(i[0] ? MIN_NEG : MAX_POS, i[0] ? MAX_POS : MIN_NEG, MINUS_ONE);
		wait_drained();

		// Long output hold-off while samples keep coming: input must back up.
		hold_req <= 1'b1;
		repeat (HOLD_BEATS)
			send_sample(pick_sample(FLAVOR_ANY), pick_sample(FLAVOR_ANY),
				pick_sample(FLAVOR_EDGE));
		wait_drained();

		while (beats_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				// constant run long enough to fill the window; edge values exercise full-scale
				flavor = ($urandom_range(0, 1) == 0) ? FLAVOR_EDGE : FLAVOR_ANY;
				cx = pick_sample(flavor);
				cy = pick_sample(flavor);
				cz = pick_sample(flavor);
				repeat ($urandom_range(WMA_WINDOW + 1, WMA_WINDOW + 8))
					send_sample(cx, cy, cz);
			end else begin
				burst = $urandom_range(1, 16);
				case ($urandom_range(0, 5))
				0:       flavor = FLAVOR_EDGE;
				1:       flavor = FLAVOR_SMALL;
				default: flavor = FLAVOR_ANY;
				endcase
				repeat (burst)
					send_sample(pick_sample(flavor), pick_sample(flavor), pick_sample(flavor));
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				smp_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/wma_pkg.sv
rtl/core/wma_in_if.sv
rtl/core/wma_out_if.sv
rtl/core/wma_ring.sv
rtl/core/wma_accum.sv
rtl/core/wma_div.sv
rtl/core/three_axis_weighted_moving_average.sv
tb/sv/wma_average_checker.sv
tb/sv/tb_three_axis_weighted_moving_average.sv
